>>> rtl/core/lrast_pkg.sv
`timescale 1ns / 1ps
// lrast_pkg: shared types and constants of the line rasterizer core
// no dependencies; used by lrast_front, lrast_back and line_rasterizer_core

package lrast_pkg;

  localparam int SCREEN_BITS = 12;
  localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RESET  = 12'd640;
  localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RESET = 12'd480;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

  typedef enum logic {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } colour_t;

  typedef struct packed {
    logic [SCREEN_BITS-1:0] width;
    logic [SCREEN_BITS-1:0] height;
  } screen_cfg_t;

  typedef struct packed {
    action_t action;
    logic    x_down;
    logic    y_down;
  } cmd_flags_t;

endpackage

>>> rtl/core/lrast_front.sv
`timescale 1ns / 1ps
// lrast_front: unpacks an input beat, classifies it and works out deltas and directions
// depends on lrast_pkg

module lrast_front #(
  parameter int COORD_BITS = 12,
  parameter int IN_W       = 72
) (
  input  logic [IN_W-1:0]       in_tdata,
  input  logic                  in_tuser,
  output lrast_pkg::cmd_flags_t flags,
  output logic [COORD_BITS-1:0] x0,
  output logic [COORD_BITS-1:0] y0,
  output logic [COORD_BITS-1:0] dx,
  output logic [COORD_BITS-1:0] dy,
  output lrast_pkg::colour_t    colour
);

  localparam int C = COORD_BITS;

  logic [C-1:0] x1;
  logic [C-1:0] y1;
  logic [C:0]   sx;
  logic [C:0]   sy;
  logic [C:0]   nsx;
  logic [C:0]   nsy;

  assign x0 = in_tdata[C-1:0];
  assign y0 = in_tdata[2*C-1:C];
  assign x1 = in_tdata[3*C-1:2*C];
  assign y1 = in_tdata[4*C-1:3*C];

  assign colour.red   = in_tdata[4*C+7:4*C];
  assign colour.green = in_tdata[4*C+15:4*C+8];
  assign colour.blue  = in_tdata[4*C+23:4*C+16];

  // signed differences, one bit wider than a coordinate
  assign sx  = {x1[C-1], x1} - {x0[C-1], x0};
  assign sy  = {y1[C-1], y1} - {y0[C-1], y0};
  assign nsx = -sx;
  assign nsy = -sy;

  assign dx = sx[C] ? nsx[C-1:0] : sx[C-1:0];
  assign dy = sy[C] ? nsy[C-1:0] : sy[C-1:0];

  assign flags.action = lrast_pkg::action_t'(in_tuser);
  assign flags.x_down = sx[C];
  assign flags.y_down = sy[C];

endmodule

>>> rtl/core/lrast_fifo.sv
`timescale 1ns / 1ps
// lrast_fifo: small register queue between front and back
// no package dependency; DEPTH is a power of two, at least 2

module lrast_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r;
  logic [AW-1:0]    rd_ptr_nxt;
  logic [AW:0]      count_r;
  logic [AW:0]      count_nxt;
  logic             push;
  logic             pop;

  assign wr_ready = (count_r != (AW+1)'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];

  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> rtl/core/lrast_back.sv
`timescale 1ns / 1ps
// lrast_back: line state, per-pixel stepping and the output register
// depends on lrast_pkg

module lrast_back #(
  parameter int COORD_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lrast_pkg::screen_cfg_t screen,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  lrast_pkg::cmd_flags_t  q_flags,
  input  logic [COORD_BITS-1:0]  q_x0,
  input  logic [COORD_BITS-1:0]  q_y0,
  input  logic [COORD_BITS-1:0]  q_dx,
  input  logic [COORD_BITS-1:0]  q_dy,
  input  lrast_pkg::colour_t     q_colour,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COORD_BITS-1:0]  pixel_x,
  output logic [COORD_BITS-1:0]  pixel_y,
  output lrast_pkg::colour_t     pixel_colour,
  output logic                   on_screen,
  output logic                   last_pixel
);

  localparam int C     = COORD_BITS;
  localparam int D     = COORD_BITS + 3;
  localparam int R     = COORD_BITS + 1;
  localparam int CMP_W = (COORD_BITS > lrast_pkg::SCREEN_BITS) ? COORD_BITS
                                                                : lrast_pkg::SCREEN_BITS;

  // line state
  logic [C-1:0]       cur_x_r,      cur_x_nxt;
  logic [C-1:0]       cur_y_r,      cur_y_nxt;
  logic [D-1:0]       decision_r,   decision_nxt;
  logic [D-1:0]       inc_ax_r,     inc_ax_nxt;
  logic [D-1:0]       inc_diag_r,   inc_diag_nxt;
  logic [R-1:0]       remaining_r,  remaining_nxt;
  logic               x_down_r,     x_down_nxt;
  logic               y_down_r,     y_down_nxt;
  logic               x_major_r,    x_major_nxt;
  lrast_pkg::colour_t colour_r,     colour_nxt;

  // output register
  logic               out_valid_r,  out_valid_nxt;
  logic [C-1:0]       px_r,         px_nxt;
  logic [C-1:0]       py_r,         py_nxt;
  lrast_pkg::colour_t pcol_r,       pcol_nxt;
  logic               onscr_r,      onscr_nxt;
  logic               last_r,       last_nxt;

  logic         pop;
  logic         s_x_major;
  logic [C-1:0] s_major;
  logic [C-1:0] s_minor;
  logic [D-1:0] s_minor2;
  logic         dec_pos;
  logic         move_x;
  logic         move_y;
  logic [C-1:0] x_new;
  logic [C-1:0] y_new;
  logic         x_in;
  logic         y_in;

  assign q_ready = !out_valid_r || out_ready;
  assign pop     = q_valid && q_ready;

  // start setup
  assign s_x_major = (q_dx >= q_dy);
  assign s_major   = s_x_major ? q_dx : q_dy;
  assign s_minor   = s_x_major ? q_dy : q_dx;
  assign s_minor2  = {2'b00, s_minor, 1'b0};

  // step
  assign dec_pos = !decision_r[D-1] && (decision_r != '0);
  assign move_x  = dec_pos || x_major_r;
  assign move_y  = dec_pos || !x_major_r;
  assign x_new   = move_x ? cur_x_r + (x_down_r ? {C{1'b1}} : C'(1)) : cur_x_r;
  assign y_new   = move_y ? cur_y_r + (y_down_r ? {C{1'b1}} : C'(1)) : cur_y_r;
  assign x_in    = !x_new[C-1] && (CMP_W'(x_new) < CMP_W'(screen.width));
  assign y_in    = !y_new[C-1] && (CMP_W'(y_new) < CMP_W'(screen.height));

  always_comb begin
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    decision_nxt  = decision_r;
    inc_ax_nxt    = inc_ax_r;
    inc_diag_nxt  = inc_diag_r;
    remaining_nxt = remaining_r;
    x_down_nxt    = x_down_r;
    y_down_nxt    = y_down_r;
    x_major_nxt   = x_major_r;
    colour_nxt    = colour_r;
    out_valid_nxt = out_valid_r && !out_ready;
    px_nxt        = px_r;
    py_nxt        = py_r;
    pcol_nxt      = pcol_r;
    onscr_nxt     = onscr_r;
    last_nxt      = last_r;
    if (pop) begin
      case (q_flags.action)
        lrast_pkg::ACT_START: begin
          cur_x_nxt     = q_x0;
          cur_y_nxt     = q_y0;
          x_down_nxt    = q_flags.x_down;
          y_down_nxt    = q_flags.y_down;
          x_major_nxt   = s_x_major;
          colour_nxt    = q_colour;
          remaining_nxt = {1'b0, s_major};
          decision_nxt  = s_minor2 - {3'b000, s_major};
          inc_ax_nxt    = s_minor2;
          inc_diag_nxt  = s_minor2 - {2'b00, s_major, 1'b0};
        end
        lrast_pkg::ACT_STEP: begin
          if (remaining_r != '0) begin
            cur_x_nxt     = x_new;
            cur_y_nxt     = y_new;
            decision_nxt  = decision_r + (dec_pos ? inc_diag_r : inc_ax_r);
            remaining_nxt = remaining_r - 1'b1;
            out_valid_nxt = 1'b1;
            px_nxt        = x_new;
            py_nxt        = y_new;
            pcol_nxt      = colour_r;
            onscr_nxt     = x_in && y_in;
            last_nxt      = (remaining_r == R'(1));
          end
        end
        default: begin
          out_valid_nxt = out_valid_r && !out_ready;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remaining_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      remaining_r <= remaining_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    decision_r <= decision_nxt;
    inc_ax_r   <= inc_ax_nxt;
    inc_diag_r <= inc_diag_nxt;
    x_down_r   <= x_down_nxt;
    y_down_r   <= y_down_nxt;
    x_major_r  <= x_major_nxt;
    colour_r   <= colour_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    pcol_r     <= pcol_nxt;
    onscr_r    <= onscr_nxt;
    last_r     <= last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign pixel_x      = px_r;
  assign pixel_y      = py_r;
  assign pixel_colour = pcol_r;
  assign on_screen    = onscr_r;
  assign last_pixel   = last_r;

endmodule

>>> rtl/core/line_rasterizer_core.sv
`timescale 1ns / 1ps
// line_rasterizer_core: top level of the integer line rasterizer
// depends on lrast_pkg, lrast_front, lrast_fifo, lrast_back
//
// usage:
//   in_*  beats carry commands. in_tuser low starts a line from the two endpoints
//   and colour in in_tdata; in_tuser high asks for the next pixel of the line.
//   out_* beats carry one pixel each: coordinates and colour in out_tdata,
//   on-screen flag in out_tuser, and out_tlast on the final pixel of the line.
//   a start beat, a step with no active line and a start on equal endpoints
//   give no output beat. the first endpoint is never emitted.
//   cfg_* writes screen width (index 0) and height (index 1); cfg_ready is
//   always high. write them only while no line work is pending.
// timing:
//   a step beat passes the front queue and then the stepping register before its
//   pixel shows on out_tvalid. while out_tready stays high one beat per cycle is
//   sustained: the back end retires one queued command per cycle and its
//   per-pixel work is one add per axis plus one add to the decision term.
// reset and stall:
//   rst_n low empties the queue, drops any active line and sets the screen to
//   640 x 480. while out_tready is low a pending pixel is held, the back end
//   stops and the 2-entry queue fills; in_tready falls only when the queue is full.

module line_rasterizer_core #(
  parameter int COORD_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // start_x, start_y, end_x, end_y, red_in, green_in, blue_in, zero pad
  input  logic [((4*COORD_BITS+24+7)/8)*8-1:0] in_tdata,
  // action
  input  logic                              in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // pixel_x, pixel_y, red_out, green_out, blue_out, zero pad
  output logic [((2*COORD_BITS+24+7)/8)*8-1:0] out_tdata,
  // on_screen
  output logic                              out_tuser,
  output logic                              out_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [lrast_pkg::SCREEN_BITS-1:0] cfg_data
);

  localparam int C     = COORD_BITS;
  localparam int IN_W  = ((4*COORD_BITS+24+7)/8)*8;
  localparam int OUT_W = ((2*COORD_BITS+24+7)/8)*8;
  localparam int FLG_W = $bits(lrast_pkg::cmd_flags_t);
  localparam int Q_W   = FLG_W + 4*COORD_BITS + 24;

  lrast_pkg::screen_cfg_t screen_r;
  lrast_pkg::screen_cfg_t screen_nxt;

  lrast_pkg::cmd_flags_t  f_flags;
  logic [C-1:0]           f_x0, f_y0, f_dx, f_dy;
  lrast_pkg::colour_t     f_colour;

  logic [Q_W-1:0]         q_wdata;
  logic [Q_W-1:0]         q_rdata;
  logic                   q_valid;
  logic                   q_ready;

  lrast_pkg::cmd_flags_t  b_flags;
  logic [C-1:0]           b_x0, b_y0, b_dx, b_dy;
  lrast_pkg::colour_t     b_colour;

  logic [C-1:0]           px, py;
  lrast_pkg::colour_t     pcol;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    screen_nxt = screen_r;
    if (cfg_valid) begin
      unique case (lrast_pkg::cfg_reg_t'(cfg_index))
        lrast_pkg::REG_SCREEN_WIDTH:  screen_nxt.width  = cfg_data;
        lrast_pkg::REG_SCREEN_HEIGHT: screen_nxt.height = cfg_data;
        default:                      screen_nxt = screen_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_r.width  <= lrast_pkg::SCREEN_WIDTH_RESET;
      screen_r.height <= lrast_pkg::SCREEN_HEIGHT_RESET;
    end else begin
      screen_r <= screen_nxt;
    end
  end

  lrast_front #(
    .COORD_BITS (COORD_BITS),
    .IN_W       (IN_W)
  ) u_front (
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .flags    (f_flags),
    .x0       (f_x0),
    .y0       (f_y0),
    .dx       (f_dx),
    .dy       (f_dy),
    .colour   (f_colour)
  );

  assign q_wdata = {f_flags, f_x0, f_y0, f_dx, f_dy, f_colour};

  lrast_fifo #(
    .WIDTH (Q_W),
    .DEPTH (2)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_tvalid),
    .wr_ready (in_tready),
    .wr_data  (q_wdata),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_rdata)
  );

  assign {b_flags, b_x0, b_y0, b_dx, b_dy, b_colour} = q_rdata;

  lrast_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .screen       (screen_r),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_flags      (b_flags),
    .q_x0         (b_x0),
    .q_y0         (b_y0),
    .q_dx         (b_dx),
    .q_dy         (b_dy),
    .q_colour     (b_colour),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .pixel_x      (px),
    .pixel_y      (py),
    .pixel_colour (pcol),
    .on_screen    (out_tuser),
    .last_pixel   (out_tlast)
  );

  assign out_tdata = OUT_W'({pcol.blue, pcol.green, pcol.red, py, px});

endmodule
